FILE: hw/rtl/gcl_pkg.sv
// Shared constants and control/status types of the GCD/LCM unit.
`timescale 1ns / 1ps
`default_nettype none

package gcl_pkg;

  localparam int DATA_BITS  = 31;
  localparam int CNT_BITS   = $clog2(DATA_BITS);
  localparam int TDATA_BITS = ((2 * DATA_BITS + 7) / 8) * 8;
  localparam int TUSER_BITS = 2;

  // tuser bit positions of the result beat
  localparam int USER_OVERFLOW = 0;
  localparam int USER_ERROR    = 1;

  typedef struct packed {
    logic load;        // capture operands, order them, flag zeros
    logic div_start;   // initialise the divider
    logic div_sel_lcm; // divider operands: op_a / gcd instead of big / small
    logic div_step;    // one restoring-division step
    logic gcd_update;  // big <= small, small <= remainder
    logic mul;         // product <= quotient * op_b
    logic out_load;    // fill the result register
  } gcl_cmd_t;

  typedef struct packed {
    logic err;         // an operand was zero
    logic small_zero;  // Euclid's loop has finished
    logic div_last;    // divider is on its final step
  } gcl_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gcl_datapath.sv
// Datapath: operand registers, shared bit-serial divider, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module gcl_datapath import gcl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [TDATA_BITS-1:0] s_tdata,
  input  wire gcl_cmd_t              cmd,
  output gcl_status_t                status,
  output logic      [TDATA_BITS-1:0] m_tdata,
  output logic      [TUSER_BITS-1:0] m_tuser
);

  localparam int D = DATA_BITS;

  logic [D-1:0]        op_a, op_b;
  logic [D-1:0]        big, lesser;
  logic                err;
  logic [D-1:0]        rem, dvd, dvs;
  logic [CNT_BITS-1:0] cnt;
  logic [2*D-1:0]      prod;

  logic [D-1:0] in_a, in_b;
  logic [D:0]   rem_sh, diff;
  logic         ge;
  logic         ovf;

  logic [D-1:0] res_div, res_mul;
  logic         res_ovf, res_err;

  assign in_a = s_tdata[D-1:0];
  assign in_b = s_tdata[2*D-1:D];

  // restoring division: quotient bits shift into dvd as dividend bits leave it
  assign rem_sh = {rem, dvd[D-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  assign ovf = |prod[2*D-1:D];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_a   <= in_a;
      op_b   <= in_b;
      big    <= (in_a > in_b) ? in_a : in_b;
      lesser <= (in_a > in_b) ? in_b : in_a;
      err    <= (in_a == '0) || (in_b == '0);
    end else if (cmd.gcd_update) begin
      big    <= lesser;
      lesser <= rem;
    end

    if (cmd.div_start) begin
      rem <= '0;
      cnt <= '0;
      dvd <= cmd.div_sel_lcm ? op_a : big;
      dvs <= cmd.div_sel_lcm ? big  : lesser;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[D-1:0] : rem_sh[D-1:0];
      dvd <= {dvd[D-2:0], ge};
      cnt <= cnt + 1'b1;
    end

    if (cmd.mul) begin
      prod <= {{D{1'b0}}, dvd} * {{D{1'b0}}, op_b};
    end

    if (cmd.out_load) begin
      if (err) begin
        res_div <= '0;
        res_mul <= '0;
        res_ovf <= 1'b0;
        res_err <= 1'b1;
      end else begin
        res_div <= big;
        res_mul <= ovf ? {D{1'b1}} : prod[D-1:0];
        res_ovf <= ovf;
        res_err <= 1'b0;
      end
    end
  end

  assign status.err        = err;
  assign status.small_zero = (lesser == '0);
  assign status.div_last   = (cnt == CNT_BITS'(D - 1));

  assign m_tdata = {{(TDATA_BITS - 2*D){1'b0}}, res_mul, res_div};
  assign m_tuser = {res_err, res_ovf};

endmodule

`default_nettype wire

FILE: hw/rtl/gcl_ctrl.sv
// Controller: sequences Euclid's loop, the quotient for the multiple and the result handshake.
`timescale 1ns / 1ps
`default_nettype none

module gcl_ctrl import gcl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire gcl_status_t status,
  output gcl_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TEST = 7'b0000010,
    S_GDIV = 7'b0000100,
    S_GUPD = 7'b0001000,
    S_LDIV = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid & ~m_tready;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (status.err) begin
          state_next = S_FIN;
        end else if (status.small_zero) begin
          cmd.div_start   = 1'b1;
          cmd.div_sel_lcm = 1'b1;
          state_next      = S_LDIV;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_GUPD;
      end
      S_GUPD: begin
        cmd.gcd_update = 1'b1;
        state_next     = S_TEST;
      end
      S_LDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gcd_lcm_unit.sv
// Top level of the GCD/LCM unit: controller, datapath and checks.
// Euclid's loop runs k remainder steps, one division each, before the quotient for the
//   multiple is formed; k is at most 44 for 31-bit operands.
// Throughput: one pair at a time, set by the single bit-serial divider (one bit a cycle).
// A zero operand skips the divider and goes straight to the result. A result waits in its
//   output register while the next pair is accepted.
// Reset (rst, synchronous, active high) clears the controller and the result valid only.
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit import gcl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata, from bit 0: first_value[30:0], second_value[30:0], zero pad
  input  wire logic [TDATA_BITS-1:0] s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata, from bit 0: divisor[30:0], multiple[30:0], zero pad
  output logic      [TDATA_BITS-1:0] m_tdata,
  // m_tuser, from bit 0: overflow, input_error
  output logic      [TUSER_BITS-1:0] m_tuser
);

  gcl_cmd_t    cmd;
  gcl_status_t status;

  // The controller owns both handshakes; the datapath only follows commands.
  gcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // One divider serves both Euclid's remainders and the op_a / gcd quotient.
  gcl_datapath u_datapath (
    .clk     (clk),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Once a pair is taken the unit is busy for at least the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready again straight after an input beat");

  // An error beat carries zeros and no overflow.
  a_error_zeros: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_ERROR]) |-> (m_tdata == '0 && !m_tuser[USER_OVERFLOW]))
    else $error("error result with non-zero fields");

  // A saturated multiple is all ones.
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_OVERFLOW]) |->
      (m_tdata[2*DATA_BITS-1:DATA_BITS] == {DATA_BITS{1'b1}}))
    else $error("overflow flagged without saturated multiple");

  // A valid pair never yields a zero divisor or a zero multiple.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[USER_ERROR]) |->
      (m_tdata[DATA_BITS-1:0] != '0 && m_tdata[2*DATA_BITS-1:DATA_BITS] != '0))
    else $error("zero divisor or multiple on a valid pair");

endmodule

`default_nettype wire
